// ===== hdl/lru_handle_cache_macros.svh =====
// ----------------------------------------------------------------------------
// lru handle cache assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef LRU_HANDLE_CACHE_MACROS_SVH
`define LRU_HANDLE_CACHE_MACROS_SVH

// same-cycle implication
`define LHC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru_handle_cache: check failed");

// next-cycle implication
`define LHC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru_handle_cache: check failed");

`endif

// ===== hdl/lhc_pkg.sv =====
// ----------------------------------------------------------------------------
// lhc_pkg
// shared constants and types of the lru handle cache
// ----------------------------------------------------------------------------
package lhc_pkg;

  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned GROUPS     = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned HANDLE_W   = 32;

  // operation codes carried in the mode field
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_PURGE  = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } lhc_entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;       // capture key compare
    logic move;      // move-to-front step
    logic push_all;  // every cell takes its neighbor (new key)
    logic purge;     // drop all entries
  } lhc_ctrl_t;

endpackage

// ===== hdl/lhc_cell.sv =====
// ----------------------------------------------------------------------------
// lhc_cell
// one slot of the recency chain: holds an entry, compares, takes neighbor
// ----------------------------------------------------------------------------
module lhc_cell import lhc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lhc_ctrl_t        ctrl_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic             sfx_i,    // a match sits here or further back
  input  lhc_entry_t       prev_i,   // entry of the more recent neighbor
  output lhc_entry_t       entry_o,
  output logic             match_o
);

  logic                valid_q, valid_d;
  logic                match_q, match_d;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                shift;

  assign shift = ctrl_i.move & (ctrl_i.push_all | sfx_i);

  always_comb begin
    valid_d = valid_q;
    match_d = match_q;
    if (ctrl_i.purge) begin
      valid_d = 1'b0;
    end else if (shift) begin
      valid_d = prev_i.valid;
    end
    if (ctrl_i.cmp) begin
      match_d = valid_q & (key_q == key_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q    <= prev_i.key;
      handle_q <= prev_i.handle;
    end
  end

  assign entry_o = '{valid: valid_q, key: key_q, handle: handle_q};
  assign match_o = match_q;

endmodule

// ===== hdl/lhc_scan.sv =====
// ----------------------------------------------------------------------------
// lhc_scan
// registered two-level scan of the match row: per-cell shift marks and hit
// ----------------------------------------------------------------------------
module lhc_scan import lhc_pkg::*; (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic [ENTRIES-1:0]               match_i,
  input  logic [ENTRIES-1:0][HANDLE_W-1:0] handle_i,
  output logic [ENTRIES-1:0]               sfx_o,
  output logic                             any_o,
  output logic [HANDLE_W-1:0]              handle_o
);

  logic [GROUPS-1:0][GROUP_SIZE-1:0]               mpad;
  logic [GROUPS-1:0][GROUP_SIZE-1:0][HANDLE_W-1:0] hpad;
  logic [GROUPS-1:0][GROUP_SIZE-1:0]               ingrp_d, ingrp_q;
  logic [GROUPS-1:0]                               gany_d, gany_q;
  logic [GROUPS-1:0][HANDLE_W-1:0]                 ghdl_d, ghdl_q;
  logic [GROUPS-1:0][GROUP_SIZE-1:0]               sfx_pad;

  assign mpad = (GROUPS*GROUP_SIZE)'(match_i);
  assign hpad = (GROUPS*GROUP_SIZE*HANDLE_W)'(handle_i);

  // first level: suffix or inside each group, group hit and handle
  always_comb begin
    logic                acc;
    logic [HANDLE_W-1:0] hacc;
    for (int g = 0; g < GROUPS; g++) begin
      acc  = 1'b0;
      hacc = '0;
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
        acc            = acc | mpad[g][j];
        ingrp_d[g][j]  = acc;
        hacc           = hacc | (mpad[g][j] ? hpad[g][j] : '0);
      end
      gany_d[g] = acc;
      ghdl_d[g] = hacc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ingrp_q <= ingrp_d;
      gany_q  <= gany_d;
      ghdl_q  <= ghdl_d;
    end
  end

  // second level: fold in hits of later groups
  always_comb begin
    logic                later;
    logic [HANDLE_W-1:0] hsum;
    later = 1'b0;
    hsum  = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
        sfx_pad[g][j] = ingrp_q[g][j] | later;
      end
      later = later | gany_q[g];
      hsum  = hsum | ghdl_q[g];
    end
    any_o    = later;
    handle_o = hsum;
  end

  assign sfx_o = ENTRIES'(sfx_pad);

endmodule

// ===== hdl/lru_handle_cache.sv =====
// ----------------------------------------------------------------------------
// lru_handle_cache
// fully associative key/handle store kept in least-recently-used order
// ----------------------------------------------------------------------------
// usage:
//   input beats on s_axis: tuser carries the mode (lookup, insert, purge),
//   tdata the key and the handle. every input beat yields exactly one
//   result beat on m_axis: tuser carries the hit and evicted flags, tdata
//   the stored handle and the evicted key.
//   an operation runs from accept through key compare in every cell, a
//   registered scan over groups of cells, and the move-to-front step that
//   shifts the chain by one cell. one operation is in flight at a time, so
//   a new beat is taken only after the move-to-front step of the last one.
//   the result sits in an output register; the next beat is accepted while
//   it waits. if the receiver stalls, the move-to-front step waits until
//   the output register is free, and no new beat is taken meanwhile.
//   reset clears every valid bit at once; no clearing pass is needed and
//   the block accepts a beat in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "lru_handle_cache_macros.svh"

module lru_handle_cache import lhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], handle [63:32]
  input  logic [1:0]  s_axis_tuser,   // mode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // stored_handle [31:0], evicted_key [63:32]
  output logic [1:0]  m_axis_tuser    // hit [0], evicted [1]
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_SCAN, S_APPLY} state_e;

  state_e                state_q, state_d;
  logic [1:0]            mode_q;
  logic [KEY_W-1:0]      key_q;
  logic [HANDLE_W-1:0]   handle_q;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic                  out_hit_q, out_evicted_q;
  logic [HANDLE_W-1:0]   out_handle_q;
  logic [KEY_W-1:0]      out_evkey_q;

  // cell chain: chain[0] is the entry offered to the front cell
  lhc_entry_t            chain [ENTRIES+1];
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    valid_vec;
  logic [ENTRIES-1:0]    sfx_vec;
  logic [ENTRIES-1:0][HANDLE_W-1:0] handle_vec;
  lhc_ctrl_t             ctrl;

  logic                  any_hit;
  logic [HANDLE_W-1:0]   hit_handle;
  logic                  in_accept;
  logic                  apply_go;
  logic                  is_lookup, is_insert_ok, is_purge;

  // result of the operation being applied
  logic                  res_hit, res_evicted;
  logic [HANDLE_W-1:0]   res_handle;
  logic [KEY_W-1:0]      res_evkey;

  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign apply_go      = (state_q == S_APPLY) & (~out_valid_q | m_axis_tready);

  assign is_lookup    = (mode_q == MODE_LOOKUP);
  assign is_insert_ok = (mode_q == MODE_INSERT) & (handle_q != '0);
  assign is_purge     = (mode_q == MODE_PURGE);

  // front entry: a hit keeps its stored handle, a new key brings its own
  assign chain[0] = '{valid: 1'b1, key: key_q, handle: any_hit ? hit_handle : handle_q};

  always_comb begin
    ctrl.cmp      = (state_q == S_CMP);
    ctrl.move     = apply_go & ((is_lookup & any_hit) | is_insert_ok);
    ctrl.push_all = ~any_hit;
    ctrl.purge    = apply_go & is_purge;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lhc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .key_i   (key_q),
      .sfx_i   (sfx_vec[i]),
      .prev_i  (chain[i]),
      .entry_o (chain[i+1]),
      .match_o (match_vec[i])
    );
    assign valid_vec[i]  = chain[i+1].valid;
    assign handle_vec[i] = chain[i+1].handle;
  end

  lhc_scan u_scan (
    .clk_i    (clk_i),
    .load_i   (state_q == S_SCAN),
    .match_i  (match_vec),
    .handle_i (handle_vec),
    .sfx_o    (sfx_vec),
    .any_o    (any_hit),
    .handle_o (hit_handle)
  );

  // the last cell drops out only when a new key enters a full chain
  always_comb begin
    res_hit     = (is_lookup & any_hit) | is_insert_ok;
    res_handle  = res_hit ? chain[0].handle : '0;
    res_evicted = is_insert_ok & ~any_hit & chain[ENTRIES].valid;
    res_evkey   = res_evicted ? chain[ENTRIES].key : '0;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_CMP;
        end
      end
      S_CMP:  state_d = S_SCAN;
      S_SCAN: state_d = S_APPLY;
      S_APPLY: begin
        if (apply_go) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q   <= s_axis_tuser;
      key_q    <= s_axis_tdata[31:0];
      handle_q <= s_axis_tdata[63:32];
    end
    if (apply_go) begin
      out_hit_q     <= res_hit;
      out_handle_q  <= res_handle;
      out_evicted_q <= res_evicted;
      out_evkey_q   <= res_evkey;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_evkey_q, out_handle_q};
  assign m_axis_tuser  = {out_evicted_q, out_hit_q};

  // valid cells always form a prefix of the chain
  `LHC_ASSERT_IMP(a_valid_prefix, 1'b1, $onehot({1'b0, valid_vec} + (ENTRIES+1)'(1)))
  // keys are unique, so at most one cell matches
  `LHC_ASSERT_IMP(a_single_match, state_q == S_SCAN, $onehot0(match_vec))
  // a result appears only out of the move-to-front step
  `LHC_ASSERT_IMP(a_result_source, $rose(m_axis_tvalid), $past(state_q == S_APPLY))
  // an accepted beat starts the compare
  `LHC_ASSERT_NXT(a_accept_cmp, in_accept, state_q == S_CMP)

endmodule
